// ----- rtl/diatonic_chord_accompaniment_defines.svh -----
// Assertion macros shared by the accompaniment RTL.
// Each macro expects signals named clk and rst in the using module.
`ifndef DIATONIC_CHORD_ACCOMPANIMENT_DEFINES_SVH
`define DIATONIC_CHORD_ACCOMPANIMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define DCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dca assertion failed");
`define DCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dca assertion failed");
`else
`define DCA_ASSERT_IMP(lbl, ante, cons)
`define DCA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/dca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dca_pkg
// Types, codes and tables of the diatonic chord accompaniment block.
// ----------------------------------------------------------------------------
package dca_pkg;

  localparam logic [2:0] REG_KEY_NOTE        = 3'd0;
  localparam logic [2:0] REG_SCALE_MODE      = 3'd1;
  localparam logic [2:0] REG_PATTERN_MODE    = 3'd2;
  localparam logic [2:0] REG_BEAT_TICKS      = 3'd3;
  localparam logic [2:0] REG_MELODY_VELOCITY = 3'd4;

  localparam logic [1:0] SCALE_MAJOR = 2'd0;
  localparam logic [1:0] SCALE_MINOR = 2'd1;
  localparam logic [1:0] SCALE_BLUES = 2'd2;

  localparam logic [1:0] PAT_ARP     = 2'd0;
  localparam logic [1:0] PAT_BLOCK   = 2'd1;
  localparam logic [1:0] PAT_ALBERTI = 2'd2;
  localparam logic [1:0] PAT_NONE    = 2'd3;

  localparam logic [12:0] LEN_MAX = 13'd8191;

  typedef struct packed {
    logic [3:0]  chord_degree;
    logic [1:0]  bar_index;
    logic [31:0] phrase_start_tick;
  } dca_in_t;

  typedef struct packed {
    logic [6:0]  note_pitch;
    logic [31:0] start_tick;
    logic [12:0] length_ticks;
    logic [5:0]  note_velocity;
    logic        last_of_bar;
  } dca_out_t;

  typedef struct packed {
    logic [6:0]  key_note;
    logic [1:0]  scale_mode;
    logic [1:0]  pattern_mode;
    logic [12:0] beat_ticks;
    logic [6:0]  melody_velocity;
  } dca_cfg_t;

  // One bar, fully classified, waiting to be played out.
  typedef struct packed {
    logic [2:0][6:0] tone;
    logic [31:0]     bar_start;
    logic [12:0]     len;
    logic [5:0]      vel;
    logic [1:0]      pattern;
    logic [12:0]     beat;
  } dca_desc_t;

  typedef struct packed {
    logic [1:0] tone_sel;
    logic [1:0] beat_mult;
    logic       add_half;
  } dca_step_t;

  function automatic logic [3:0] scale_step(input logic minor, input logic [2:0] idx);
    logic [3:0] v;
    case (idx)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd2;
      3'd2:    v = minor ? 4'd3 : 4'd4;
      3'd3:    v = 4'd5;
      3'd4:    v = 4'd7;
      3'd5:    v = minor ? 4'd8 : 4'd9;
      3'd6:    v = minor ? 4'd10 : 4'd11;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] note_count(input logic [1:0] pattern);
    logic [3:0] n;
    case (pattern)
      PAT_ARP:     n = 4'd4;
      PAT_BLOCK:   n = 4'd6;
      PAT_ALBERTI: n = 4'd8;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

  // Tone choice and time offset of note k within a bar's run.
  function automatic dca_step_t step_info(input logic [1:0] pattern, input logic [2:0] k);
    dca_step_t s;
    s = '0;
    case (pattern)
      PAT_ARP: begin
        s.tone_sel  = (k[1:0] == 2'd3) ? 2'd1 : k[1:0];
        s.beat_mult = k[1:0];
      end
      PAT_BLOCK: begin
        s.tone_sel  = (k >= 3'd3) ? 2'(k - 3'd3) : k[1:0];
        s.beat_mult = (k >= 3'd3) ? 2'd2 : 2'd0;
      end
      PAT_ALBERTI: begin
        case (k[1:0])
          2'd0:    s.tone_sel = 2'd0;
          2'd2:    s.tone_sel = 2'd1;
          default: s.tone_sel = 2'd2;
        endcase
        s.beat_mult = k[2:1];
        s.add_half  = k[0];
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/diatonic_chord_accompaniment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diatonic_chord_accompaniment
// Turns one bar item into a run of triad notes for the accompaniment.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while no bar is in flight.
//   Input: one item per bar on in_valid/in_ready (in_data).
//   Output: one note item per cycle while out_ready is high, on out_valid/out_ready (out_data);
//   last_of_bar marks the final note of a bar.
// Flow:
//   Once the bar is accepted, its first note passes through the queue and
//   then the output register, when the queue and the output register are empty.
//   A bar yields 4 (arpeggio), 6 (block) or 8 (Alberti) notes, one per
//   cycle while out_ready is high; a bar in the silent pattern is accepted
//   and yields nothing. The note counter in the back end sets that rate;
//   a two-bar queue lets the next bars be accepted while the current one
//   plays out.
// Reset: clears the queue and output register and loads the default
//   configuration (key 60, major, arpeggio, 480 ticks, velocity 100).
// Stall: a low out_ready holds the output note; the queue then fills
//   and in_ready falls.
// ----------------------------------------------------------------------------
module diatonic_chord_accompaniment import dca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  dca_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output dca_out_t    out_data
);

  dca_cfg_t  cfg;
  logic      push_valid;
  logic      push_ready;
  dca_desc_t push_desc;
  logic      head_valid;
  dca_desc_t head_desc;
  logic      pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_note        <= 7'd60;
      cfg.scale_mode      <= SCALE_MAJOR;
      cfg.pattern_mode    <= PAT_ARP;
      cfg.beat_ticks      <= 13'd480;
      cfg.melody_velocity <= 7'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_NOTE:        cfg.key_note        <= cfg_data[6:0];
        REG_SCALE_MODE:      cfg.scale_mode      <= cfg_data[1:0];
        REG_PATTERN_MODE:    cfg.pattern_mode    <= cfg_data[1:0];
        REG_BEAT_TICKS:      cfg.beat_ticks      <= cfg_data;
        REG_MELODY_VELOCITY: cfg.melody_velocity <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  dca_front u_front (
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  dca_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .head_valid (head_valid),
    .pop        (pop),
    .head_desc  (head_desc)
  );

  dca_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/dca_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dca_front
// Takes bar items, builds the triad, bar start and note length of each bar.
// ----------------------------------------------------------------------------
module dca_front import dca_pkg::*; (
  input  dca_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  dca_in_t   in_data,
  output logic      push_valid,
  input  logic      push_ready,
  output dca_desc_t push_desc
);

  // 2^21/5 rounded up; exact for dividends below 2^19.
  localparam logic [18:0] RECIP5 = 19'd419431;

  logic        minor;
  logic [18:0] dividend;
  logic [37:0] product;
  logic [16:0] quotient;
  logic [14:0] bar_mult;

  function automatic logic [6:0] tone_pitch(input logic [6:0] key, input logic minor_tab,
                                            input logic [3:0] degree, input logic [1:0] step);
    logic [4:0]        d;
    logic [1:0]        oct;
    logic [2:0]        rem;
    logic signed [9:0] p;
    d = 5'(degree) + 5'({step, 1'b0});
    if (d >= 5'd14) begin
      oct = 2'd2;
      rem = 3'(d - 5'd14);
    end else if (d >= 5'd7) begin
      oct = 2'd1;
      rem = 3'(d - 5'd7);
    end else begin
      oct = 2'd0;
      rem = d[2:0];
    end
    p = $signed({3'b0, key}) - 10'sd12 + $signed({3'b0, oct, 2'b0} * 10'd3)
        + $signed({6'b0, scale_step(minor_tab, rem)});
    if (p < 10'sd0)
      return 7'd0;
    else if (p > 10'sd127)
      return 7'd127;
    else
      return p[6:0];
  endfunction

  assign minor = (cfg.scale_mode == SCALE_MINOR) || (cfg.scale_mode == SCALE_BLUES);

  // Lengths are beat*17/20, beat*9/5 and beat*2/5, each a divide by five.
  always_comb begin
    case (cfg.pattern_mode)
      PAT_ARP:   dividend = 19'(({6'b0, cfg.beat_ticks} * 19'd17) >> 2);
      PAT_BLOCK: dividend = {6'b0, cfg.beat_ticks} * 19'd9;
      default:   dividend = {5'b0, cfg.beat_ticks, 1'b0};
    endcase
  end

  assign product  = {19'b0, dividend} * {19'b0, RECIP5};
  assign quotient = product[37:21];
  assign bar_mult = 15'(in_data.bar_index) * {2'b0, cfg.beat_ticks};

  always_comb begin
    push_desc.tone[0]   = tone_pitch(cfg.key_note, minor, in_data.chord_degree, 2'd0);
    push_desc.tone[1]   = tone_pitch(cfg.key_note, minor, in_data.chord_degree, 2'd1);
    push_desc.tone[2]   = tone_pitch(cfg.key_note, minor, in_data.chord_degree, 2'd2);
    push_desc.bar_start = in_data.phrase_start_tick + {15'b0, bar_mult, 2'b0};
    push_desc.len       = (quotient > {4'b0, LEN_MAX}) ? LEN_MAX : quotient[12:0];
    push_desc.vel       = cfg.melody_velocity[6:1];
    push_desc.pattern   = cfg.pattern_mode;
    push_desc.beat      = cfg.beat_ticks;
  end

  // A bar in the silent pattern is taken and dropped here.
  assign in_ready   = push_ready;
  assign push_valid = in_valid && (cfg.pattern_mode != PAT_NONE);

endmodule

// ----- rtl/dca_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dca_queue
// Two-entry queue of bar descriptors between the front and the back.
// ----------------------------------------------------------------------------
`include "diatonic_chord_accompaniment_defines.svh"

module dca_queue import dca_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  dca_desc_t push_desc,
  output logic      head_valid,
  input  logic      pop,
  output dca_desc_t head_desc
);

  dca_desc_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_fire;
  logic       pop_fire;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_desc  = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push_fire} - {1'b0, pop_fire};
    end
  end

  `DCA_ASSERT_IMP(a_q_bound, 1'b1, count <= 2'd2)
  `DCA_ASSERT_NXT(a_q_track, 1'b1,
                  count == $past(count) + {1'b0, $past(push_fire)} - {1'b0, $past(pop_fire)})

endmodule

// ----- rtl/dca_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dca_back
// Plays out the head bar of the queue, one note per cycle while out_ready is
// high, into an output register.
// ----------------------------------------------------------------------------
`include "diatonic_chord_accompaniment_defines.svh"

module dca_back import dca_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  dca_desc_t head_desc,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output dca_out_t  out_data
);

  logic [2:0]  idx;
  logic [3:0]  n_notes;
  logic        is_last;
  logic        load;
  dca_step_t   step;
  logic [14:0] offset;
  dca_out_t    note;

  assign n_notes = note_count(head_desc.pattern);
  assign is_last = ({1'b0, idx} == n_notes - 4'd1);
  assign load    = head_valid && (!out_valid || out_ready);
  assign pop     = load && is_last;
  assign step    = step_info(head_desc.pattern, idx);
  assign offset  = 15'(step.beat_mult) * {2'b0, head_desc.beat}
                   + (step.add_half ? {3'b0, head_desc.beat[12:1]} : 15'd0);

  always_comb begin
    note.note_pitch    = head_desc.tone[step.tone_sel];
    note.start_tick    = head_desc.bar_start + {17'b0, offset};
    note.length_ticks  = head_desc.len;
    note.note_velocity = head_desc.vel;
    note.last_of_bar   = is_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= note;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DCA_ASSERT_IMP(a_b_idx_range, head_valid, {1'b0, idx} < n_notes)
  `DCA_ASSERT_NXT(a_b_advance, load && !is_last, idx == $past(idx) + 3'd1)
  `DCA_ASSERT_IMP(a_b_idle_idx, !head_valid, idx == 3'd0)

endmodule

// ----- tb/diatonic_chord_accompaniment_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diatonic_chord_accompaniment_checker
// Follows the register writes, predicts the note run of every accepted bar and
// compares each accepted note, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module diatonic_chord_accompaniment_checker import dca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  dca_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  dca_out_t    out_data,
  input  logic        flush,
  output int          fail_count,
  output int          notes_pending
);

  localparam logic [6:0][3:0] MAJOR_STEPS = {4'd11, 4'd9, 4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
  localparam logic [6:0][3:0] MINOR_STEPS = {4'd10, 4'd8, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
  localparam logic [3:0][1:0] ARP_ORDER     = {2'd1, 2'd2, 2'd1, 2'd0};
  localparam logic [3:0][1:0] ALBERTI_ORDER = {2'd2, 2'd1, 2'd2, 2'd0};
  localparam int OCTAVE = 12;

  logic [6:0]  key_note;
  logic [1:0]  scale_mode;
  logic [1:0]  pattern_mode;
  logic [12:0] beat_ticks;
  logic [6:0]  melody_velocity;

  dca_out_t expected_notes[$];
  int errors = 0;

  // Pitch of one chord tone (0 root, 1 third, 2 fifth), clamped to MIDI range.
  function automatic logic [6:0] triad_tone(input logic [3:0] degree, input int step);
    int d;
    int p;
    logic [3:0] offset;
    d = int'(degree) + 2 * step;
    if (scale_mode == SCALE_MINOR || scale_mode == SCALE_BLUES) offset = MINOR_STEPS[d % 7];
    else offset = MAJOR_STEPS[d % 7];
    p = int'(key_note) - OCTAVE + (d / 7) * OCTAVE + int'(offset);
    if (p < 0) p = 0;
    else if (p > 127) p = 127;
    return 7'(p);
  endfunction

  function automatic logic [12:0] beat_fraction(input int unsigned num, input int unsigned den);
    int unsigned v;
    v = ({19'd0, beat_ticks} * num) / den;
    if (v > LEN_MAX) return LEN_MAX;
    return 13'(v);
  endfunction

  function automatic void predict_bar(input dca_in_t bar);
    logic [2:0][6:0] tones;
    logic [31:0]     beat32;
    logic [31:0]     bar_start;
    logic [31:0]     offset;
    logic [12:0]     len;
    int              count;
    int              k;
    dca_out_t        note;
    case (pattern_mode)
      PAT_ARP: begin
        count = 4;
        len = beat_fraction(85, 100);
      end
      PAT_BLOCK: begin
        count = 6;
        len = beat_fraction(18, 10);
      end
      PAT_ALBERTI: begin
        count = 8;
        len = beat_fraction(4, 10);
      end
      default: begin
        count = 0;
        len = '0;
      end
    endcase
    for (k = 0; k < 3; k++) tones[k] = triad_tone(bar.chord_degree, k);
    beat32 = 32'(beat_ticks);
    bar_start = bar.phrase_start_tick + 32'(bar.bar_index) * 32'd4 * beat32;
    for (k = 0; k < count; k++) begin
      case (pattern_mode)
        PAT_ARP: begin
          note.note_pitch = tones[ARP_ORDER[k]];
          offset = 32'(k) * beat32;
        end
        PAT_BLOCK: begin
          note.note_pitch = tones[k % 3];
          offset = 32'(k / 3) * 32'd2 * beat32;
        end
        default: begin
          note.note_pitch = tones[ALBERTI_ORDER[k % 4]];
          offset = 32'(k / 2) * beat32 + 32'(k % 2) * (beat32 >> 1);
        end
      endcase
      note.start_tick    = bar_start + offset;
      note.length_ticks  = len;
      note.note_velocity = melody_velocity[6:1];
      note.last_of_bar   = (k == count - 1);
      expected_notes.insert(expected_notes.size(), note);
    end
  endfunction

  always @(posedge clk) begin
    dca_out_t want;
    if (rst) begin
      key_note        = 7'd60;
      scale_mode      = SCALE_MAJOR;
      pattern_mode    = PAT_ARP;
      beat_ticks      = 13'd480;
      melody_velocity = 7'd100;
      expected_notes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_NOTE:        key_note = cfg_data[6:0];
          REG_SCALE_MODE:      scale_mode = cfg_data[1:0];
          REG_PATTERN_MODE:    pattern_mode = cfg_data[1:0];
          REG_BEAT_TICKS:      beat_ticks = cfg_data;
          REG_MELODY_VELOCITY: melody_velocity = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_bar(in_data);
      if (out_valid && out_ready) begin
        if (expected_notes.size() == 0) begin
          $error("note with no bar waiting: pitch %0d start %0d", out_data.note_pitch,
                 out_data.start_tick);
          errors++;
        end else begin
          want = expected_notes.pop_front();
          if (out_data.note_pitch !== want.note_pitch) begin
            $error("note_pitch: expected %0d, actual %0d", want.note_pitch,
                   out_data.note_pitch);
            errors++;
          end
          if (out_data.start_tick !== want.start_tick) begin
            $error("start_tick: expected %0d, actual %0d", want.start_tick,
                   out_data.start_tick);
            errors++;
          end
          if (out_data.length_ticks !== want.length_ticks) begin
            $error("length_ticks: expected %0d, actual %0d", want.length_ticks,
                   out_data.length_ticks);
            errors++;
          end
          if (out_data.note_velocity !== want.note_velocity) begin
            $error("note_velocity: expected %0d, actual %0d", want.note_velocity,
                   out_data.note_velocity);
            errors++;
          end
          if (out_data.last_of_bar !== want.last_of_bar) begin
            $error("last_of_bar: expected %0d, actual %0d", want.last_of_bar,
                   out_data.last_of_bar);
            errors++;
          end
        end
      end
      if (flush && expected_notes.size() != 0) begin
        $error("%0d predicted notes never arrived", expected_notes.size());
        errors += expected_notes.size();
        expected_notes.delete();
      end
    end
    fail_count    <= errors;
    notes_pending <= expected_notes.size();
  end

endmodule

// ----- tb/diatonic_chord_accompaniment_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diatonic_chord_accompaniment_test
// Drives bar items and register settings into the accompaniment block with
// random gaps and output stalls; the checker beside it predicts every note.
// ----------------------------------------------------------------------------
module diatonic_chord_accompaniment_test;
  import dca_pkg::*;

  localparam int BAR_TARGET    = 430;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [1:0] SCALE_UNUSED = 2'd3;

  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_SPARSE} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  dca_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  dca_out_t    out_data;
  logic        flush = 1'b0;
  int          fail_count;
  int          notes_pending;

  int          cycle_count = 0;
  int          burst_left = 0;
  int          sounding_bars = 0;
  logic [1:0]  cur_pattern = PAT_ARP;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_left = 0;

  diatonic_chord_accompaniment i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  diatonic_chord_accompaniment_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .flush         (flush),
    .fail_count    (fail_count),
    .notes_pending (notes_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The note receiver moves to a new, randomly chosen stall pattern whenever its countdown runs out.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(32, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
      RDY_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
      default:    out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Leaves cfg_valid high so that back-to-back writes need not raise it again.
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Holds off new bars until every predicted note is out and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (notes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [6:0] key, input logic [1:0] scale,
                                input logic [1:0] pattern, input logic [12:0] beat,
                                input logic [6:0] vel, input bit junk);
    logic [12:0] pad;
    settle();
    pad = junk ? 13'($urandom) : '0;
    if (junk) write_reg(3'($urandom_range(int'(REG_MELODY_VELOCITY) + 1, 7)), 13'($urandom));
    write_reg(REG_KEY_NOTE, {pad[12:7], key});
    write_reg(REG_SCALE_MODE, {pad[12:2], scale});
    write_reg(REG_PATTERN_MODE, {pad[12:2], pattern});
    write_reg(REG_BEAT_TICKS, beat);
    write_reg(REG_MELODY_VELOCITY, {pad[12:7], vel});
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_pattern = pattern;
  endtask

  task automatic send_bar(input dca_in_t bar);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= bar;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (cur_pattern != PAT_NONE) sounding_bars++;
  endtask

  function automatic dca_in_t make_bar(input logic [3:0] degree, input logic [1:0] idx,
                                       input logic [31:0] t0);
    dca_in_t b;
    b.chord_degree      = degree;
    b.bar_index         = idx;
    b.phrase_start_tick = t0;
    return b;
  endfunction

  function automatic dca_in_t random_bar();
    dca_in_t b;
    if ($urandom_range(0, 9) == 0) b.chord_degree = 4'($urandom_range(0, 15));
    else b.chord_degree = 4'($urandom_range(0, 13));
    b.bar_index = 2'($urandom_range(0, 3));
    // Phrase starts close to the top of the tick range make the times wrap.
    if ($urandom_range(0, 4) == 0)
      b.phrase_start_tick = 32'hFFFF_FFFF - 32'($urandom_range(0, 40000));
    else b.phrase_start_tick = $urandom;
    return b;
  endfunction

  initial begin
    int          pick;
    int          count;
    int          r;
    logic [6:0]  key;
    logic [1:0]  scale;
    logic [1:0]  pattern;
    logic [12:0] beat;
    logic [6:0]  vel;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register values straight out of reset.
    send_bar(make_bar(4'd0, 2'd0, 32'd0));
    send_bar(make_bar(4'd13, 2'd3, 32'hFFFF_FFFF));
    send_bar(make_bar(4'd15, 2'd1, $urandom));

    apply_settings(7'd71, SCALE_MINOR, PAT_BLOCK, 13'd4096, 7'd127, 1'b0);
    send_bar(make_bar(4'd7, 2'd2, $urandom));
    send_bar(make_bar(4'd14, 2'd3, 32'hFFFF_F000));

    // Key at zero pushes the low tones below the MIDI range; odd beat length.
    apply_settings(7'd0, SCALE_BLUES, PAT_ALBERTI, 13'd7, 7'd1, 1'b0);
    send_bar(make_bar(4'd0, 2'd0, $urandom));
    send_bar(make_bar(4'd3, 2'd1, $urandom));

    // Top key saturates high; the longest beat is played in the Alberti pattern.
    apply_settings(7'd127, SCALE_UNUSED, PAT_ALBERTI, 13'd8191, 7'd0, 1'b0);
    send_bar(make_bar(4'd15, 2'd3, 32'hFFFF_FFFF));
    send_bar(make_bar(4'd0, 2'd0, 32'd0));

    apply_settings(7'd65, SCALE_MAJOR, PAT_ARP, 13'd0, 7'd64, 1'b0);
    send_bar(make_bar(4'd5, 2'd2, $urandom));

    apply_settings(7'd60, SCALE_MAJOR, PAT_NONE, 13'd480, 7'd100, 1'b0);
    repeat (3) send_bar(random_bar());

    apply_settings(7'd60, SCALE_MINOR, PAT_BLOCK, 13'd2, 7'd2, 1'b1);
    send_bar(make_bar(4'd1, 2'd0, $urandom));
    send_bar(make_bar(4'd12, 2'd1, $urandom));

    sounding_bars = 0;
    while (sounding_bars < BAR_TARGET) begin
      if ($urandom_range(0, 4) == 0) key = 7'($urandom_range(0, 127));
      else key = 7'($urandom_range(60, 71));
      scale = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      if (pick < 3) pattern = PAT_ARP;
      else if (pick < 6) pattern = PAT_BLOCK;
      else if (pick < 9) pattern = PAT_ALBERTI;
      else pattern = PAT_NONE;
      r = $urandom_range(0, 19);
      if (r < 12) beat = 13'($urandom_range(2, 600));
      else if (r < 17) beat = 13'($urandom_range(2, 4096));
      else if (r < 19) beat = 13'($urandom_range(4097, 8191));
      else beat = 13'($urandom_range(0, 3));
      vel = 7'($urandom_range(0, 127));
      apply_settings(key, scale, pattern, beat, vel, $urandom_range(0, 3) == 0);
      count = (pattern == PAT_NONE) ? $urandom_range(3, 8) : $urandom_range(15, 50);
      repeat (count) send_bar(random_bar());
    end

    settle();
    flush <= 1'b1;
    @(posedge clk);
    flush <= 1'b0;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
